@@ hw/rtl/fba_pkg.sv @@
package fba_pkg;

    localparam int MAX_BLOCKS  = 1024;
    localparam int LINE_BYTES  = 64;
    localparam int LINE_SHIFT  = $clog2(LINE_BYTES);

    localparam int ADDR_W      = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_BYTES_W = 17;
    localparam int CFG_COUNT_W = 11;
    localparam int STATUS_W    = 3;

    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int LINES_W = CFG_BYTES_W - LINE_SHIFT + 1;
    localparam int QUO_W   = ADDR_W - LINE_SHIFT;
    localparam int PROD_W  = IDX_W + LINES_W;

    localparam logic [CFG_BYTES_W-1:0] BYTES_RESET = CFG_BYTES_W'(64);
    localparam logic [CFG_COUNT_W-1:0] COUNT_RESET = CFG_COUNT_W'(1024);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = CFG_IDX_W'(2);

    localparam logic [STATUS_W-1:0] STAT_OK        = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STAT_NULL      = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] STAT_MISALIGN  = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] STAT_RANGE     = STATUS_W'(4);
    localparam logic [STATUS_W-1:0] STAT_NOT_ALLOC = STATUS_W'(5);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] free_address;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   block_address;
        logic [CNT_W-1:0]    free_count;
        logic [CNT_W-1:0]    used_count;
    } t_rsp;

    typedef struct packed {
        logic [QUO_W-1:0]   quot;
        logic [LINES_W-1:0] rem;
    } t_div_res;

    // Zero acts as one block, anything above the maximum saturates.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_COUNT_W-1:0] c);
        logic [CNT_W-1:0] v;
        if (c == '0) begin
            v = CNT_W'(1);
        end else if (32'(c) > 32'(MAX_BLOCKS)) begin
            v = CNT_W'(MAX_BLOCKS);
        end else begin
            v = CNT_W'(c);
        end
        return v;
    endfunction

    // Block size in whole lines; zero bytes acts as one line.
    function automatic logic [LINES_W-1:0] eff_lines(input logic [CFG_BYTES_W-1:0] b);
        logic [CFG_BYTES_W:0] sum;
        logic [LINES_W-1:0]   v;
        sum = {1'b0, b} + (CFG_BYTES_W+1)'(LINE_BYTES - 1);
        if (b == '0) begin
            v = LINES_W'(1);
        end else begin
            v = sum[CFG_BYTES_W:LINE_SHIFT];
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/fba_ram.sv @@
module fba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/fba_div.sv @@
module fba_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fba_pkg::QUO_W-1:0]     i_dividend,
    input  logic [fba_pkg::LINES_W-1:0]   i_divisor,
    output logic                          o_done,
    output fba_pkg::t_div_res             o_res
);
    import fba_pkg::*;

    localparam int DCNT_W = $clog2(QUO_W);
    localparam logic [DCNT_W-1:0] CNT_LAST = DCNT_W'(QUO_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [DCNT_W-1:0]  r_cnt;
    logic [QUO_W-1:0]   r_quo;
    logic [LINES_W-1:0] r_rem;
    logic [LINES_W-1:0] r_dvs;

    logic [LINES_W:0]   w_trial;
    logic [LINES_W:0]   w_diff;
    logic               w_take;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_take  = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[QUO_W-2:0], w_take};
                r_rem <= w_take ? w_diff[LINES_W-1:0] : w_trial[LINES_W-1:0];
                r_cnt <= r_cnt + DCNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_res.quot = r_quo;
    assign o_res.rem  = r_rem;

endmodule

@@ hw/rtl/fixed_block_allocator_core.sv @@
// Fixed-size block allocator with a LIFO free stack.
//
// Request channel: i_valid / o_stall carry i_req (func, free_address).
// Response channel: o_valid / i_stall carry o_rsp (status, block_address,
// free_count, used_count). Every request gives one response unless a block count write comes first.
// Configuration: i_cfg_we writes base (0), block bytes (1) or block count (2).
// Writing the block count rebuilds the free stack and clears the in-use bits.
//
// One request is in work at a time; o_stall is low only while idle.
// Allocate: read the free stack, multiply the index by the block lines, add the
// base (S_ALLOC_RD, S_ALLOC_MUL, S_ALLOC_ADD). Free: the radix-2 divider takes the
// line offset apart one quotient bit per cycle (26 steps), then the in-use bit is
// read (S_FREE_RD, S_FREE_CHK); a remainder or range failure answers straight after
// the divide. Failed checks before the divide answer straight from idle. With the
// receiver ready, the core is back in idle as o_valid rises.
// The response sits in an output register; a new request is taken while it
// waits, and a stalled response holds until taken. The next result waits for it.
// After reset and after each block count write, a clearing pass over all 1024 entries
// wipes the in-use memory; no request is taken meanwhile.
module fixed_block_allocator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  fba_pkg::t_req                     i_req,
    output logic                              o_valid,
    input  logic                              i_stall,
    output fba_pkg::t_rsp                     o_rsp,
    input  logic                              i_cfg_we,
    input  logic [fba_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fba_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import fba_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_MUL,
        S_ALLOC_ADD,
        S_DIV,
        S_FREE_RD,
        S_FREE_CHK,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [ADDR_W-1:0]      r_base;
    logic [CFG_BYTES_W-1:0] r_bytes;
    logic [CFG_COUNT_W-1:0] r_count;
    logic [CNT_W-1:0]       r_top;
    logic [CNT_W-1:0]       r_low;
    logic [CNT_W-1:0]       r_pos;
    logic                   r_from_ram;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_clr;
    logic [PROD_W-1:0]      r_prod;
    logic [STATUS_W-1:0]    r_status;
    logic [ADDR_W-1:0]      r_addr;
    logic                   r_out_valid;
    t_rsp                   r_rsp;

    logic [CNT_W-1:0]   w_n;
    logic [CNT_W-1:0]   w_new_n;
    logic [LINES_W-1:0] w_lines;
    logic [ADDR_W-1:0]  w_off;
    logic               w_null;
    logic               w_aligned;
    logic               w_accept;
    logic               w_load;
    logic               w_rebuild;
    logic               w_div_start;
    logic               w_div_done;
    t_div_res           w_div_res;
    logic [IDX_W-1:0]   w_stk_q;
    logic [IDX_W-1:0]   w_pop_idx;
    logic               w_stk_we;
    logic [0:0]         w_use_q;
    logic               w_use_we;
    logic [IDX_W-1:0]   w_use_waddr;
    logic [0:0]         w_use_wdata;
    logic [CNT_W-1:0]   w_top_dec;

    assign w_n       = eff_count(r_count);
    assign w_new_n   = eff_count(i_cfg_data[CFG_COUNT_W-1:0]);
    assign w_lines   = eff_lines(r_bytes);
    assign w_off     = i_req.free_address - r_base;
    assign w_null    = (i_req.free_address == '0) || (i_req.free_address < r_base);
    assign w_aligned = (w_off[LINE_SHIFT-1:0] == '0);
    assign w_accept  = i_valid && (r_state == S_IDLE);
    assign w_top_dec = r_top - CNT_W'(1);
    assign w_load    = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    assign w_rebuild = i_cfg_we && (i_cfg_idx == CFG_COUNT);

    assign w_div_start = w_accept && (i_req.func == FUNC_FREE) && !w_null && w_aligned;

    // Stack slots below the low-water mark were never written since the rebuild.
    assign w_pop_idx = r_from_ram ? w_stk_q : r_pos[IDX_W-1:0];

    fba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_off[ADDR_W-1:LINE_SHIFT]),
        .i_divisor  (w_lines),
        .o_done     (w_div_done),
        .o_res      (w_div_res)
    );

    assign w_stk_we = (r_state == S_FREE_CHK) && w_use_q[0];

    fba_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BLOCKS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (r_top[IDX_W-1:0]),
        .i_wdata (r_idx),
        .i_raddr (r_pos[IDX_W-1:0]),
        .o_rdata (w_stk_q)
    );

    always_comb begin
        w_use_we    = 1'b0;
        w_use_waddr = r_idx;
        w_use_wdata = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_use_we    = 1'b1;
                w_use_waddr = r_clr;
            end
            S_ALLOC_MUL: begin
                w_use_we    = 1'b1;
                w_use_waddr = w_pop_idx;
                w_use_wdata = 1'b1;
            end
            S_FREE_CHK: begin
                w_use_we = w_use_q[0];
            end
            default: begin
                w_use_we = 1'b0;
            end
        endcase
    end

    fba_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_in_use (
        .i_clk   (i_clk),
        .i_we    (w_use_we),
        .i_waddr (w_use_waddr),
        .i_wdata (w_use_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_use_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_base      <= '0;
            r_bytes     <= BYTES_RESET;
            r_count     <= COUNT_RESET;
            r_top       <= eff_count(COUNT_RESET);
            r_low       <= eff_count(COUNT_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (w_rebuild) begin
                // Rebuild: identity stack, clear all in-use bits.
                r_count <= i_cfg_data[CFG_COUNT_W-1:0];
                r_top   <= w_new_n;
                r_low   <= w_new_n;
                r_clr   <= '0;
                r_state <= S_CLEAR;
            end else begin
                case (r_state)
                    S_CLEAR: begin
                        r_clr <= r_clr + IDX_W'(1);
                        if (r_clr == IDX_W'(MAX_BLOCKS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (i_valid) begin
                            r_addr <= '0;
                            if (i_req.func == FUNC_ALLOC) begin
                                if (r_top == '0) begin
                                    r_status <= STAT_EXHAUSTED;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_pos      <= w_top_dec;
                                    r_top      <= w_top_dec;
                                    r_from_ram <= (w_top_dec >= r_low);
                                    if (w_top_dec < r_low) begin
                                        r_low <= w_top_dec;
                                    end
                                    r_state <= S_ALLOC_RD;
                                end
                            end else if (w_null) begin
                                r_status <= STAT_NULL;
                                r_state  <= S_DONE;
                            end else if (!w_aligned) begin
                                r_status <= STAT_MISALIGN;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                    end
                    S_ALLOC_RD: begin
                        r_state <= S_ALLOC_MUL;
                    end
                    S_ALLOC_MUL: begin
                        r_idx   <= w_pop_idx;
                        r_prod  <= PROD_W'(w_pop_idx) * PROD_W'(w_lines);
                        r_state <= S_ALLOC_ADD;
                    end
                    S_ALLOC_ADD: begin
                        r_addr   <= r_base + (ADDR_W'(r_prod) << LINE_SHIFT);
                        r_status <= STAT_OK;
                        r_state  <= S_DONE;
                    end
                    S_DIV: begin
                        if (w_div_done) begin
                            if (w_div_res.rem != '0) begin
                                r_status <= STAT_MISALIGN;
                                r_state  <= S_DONE;
                            end else if (w_div_res.quot >= QUO_W'(w_n)) begin
                                r_status <= STAT_RANGE;
                                r_state  <= S_DONE;
                            end else begin
                                r_idx   <= w_div_res.quot[IDX_W-1:0];
                                r_state <= S_FREE_RD;
                            end
                        end
                    end
                    S_FREE_RD: begin
                        r_state <= S_FREE_CHK;
                    end
                    S_FREE_CHK: begin
                        if (w_use_q[0]) begin
                            r_top    <= r_top + CNT_W'(1);
                            r_status <= STAT_OK;
                        end else begin
                            r_status <= STAT_NOT_ALLOC;
                        end
                        r_state <= S_DONE;
                    end
                    S_DONE: begin
                        // Load the response once the output register is free.
                        if (w_load) begin
                            r_rsp.status        <= r_status;
                            r_rsp.block_address <= r_addr;
                            r_rsp.free_count    <= r_top;
                            r_rsp.used_count    <= w_n - r_top;
                            r_state             <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE: begin
                        r_base <= i_cfg_data[ADDR_W-1:0];
                    end
                    CFG_BYTES: begin
                        r_bytes <= i_cfg_data[CFG_BYTES_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    a_top_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= w_n)
        else $error("free count exceeds block count");

    a_low_water: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_top)
        else $error("stack low-water mark above stack top");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside of a free request");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted without leaving idle");

endmodule
